// ===== design/mlbf_pkg.sv =====
// Shared types and constants for the multi-LED breathing fader.
// Used by the front, queue, back and top-level modules; no dependencies.
package mlbf_pkg;

  localparam int REG_COUNT = 5;   // slice mapping registers
  localparam int MASK_W    = 8;   // one pending bit per PWM slice
  localparam int SLICE_W   = 3;
  localparam int LED_W     = 3;
  localparam int LEVEL_W   = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFFFF;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LED0 = 3'd0;
  localparam logic [2:0] REG_LED1 = 3'd1;
  localparam logic [2:0] REG_LED2 = 3'd2;
  localparam logic [2:0] REG_LED3 = 3'd3;
  localparam logic [2:0] REG_LED4 = 3'd4;

  // Slice number for each LED, LED 0 in the lowest entry
  typedef logic [REG_COUNT-1:0][SLICE_W-1:0] slice_map_t;

  // Classified wrap event, front to back
  typedef struct packed {
    logic               no_req;
    logic               iterate;
    logic [SLICE_W-1:0] slice;
    logic [LED_W-1:0]   led;
  } evt_t;

  // Result of one wrap event
  typedef struct packed {
    logic               no_request;
    logic [SLICE_W-1:0] serviced_slice;
    logic [LEVEL_W-1:0] duty_level;
    logic               rotated;
    logic [SLICE_W-1:0] disabled_slice;
    logic [SLICE_W-1:0] enabled_slice;
    logic [LED_W-1:0]   active_led;
  } res_t;

endpackage

// ===== design/mlbf_front.sv =====
// Front end: picks the lowest pending slice and maps it to an LED index.
// Depends on mlbf_pkg.
module mlbf_front import mlbf_pkg::*; #(
  parameter int LED_COUNT = 5
) (
  input  logic [MASK_W-1:0] pending_mask,
  input  logic              iterate_enable,
  input  slice_map_t        slice_map,
  output evt_t              evt
);

  logic [SLICE_W-1:0] slice;
  logic [LED_W-1:0]   led;

  // Lowest set bit of the pending mask
  always_comb begin
    slice = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (pending_mask[i]) begin
        slice = SLICE_W'(i);
      end
    end
  end

  // Lowest LED whose slice matches; unmatched slices go to LED 0
  always_comb begin
    led = '0;
    for (int i = LED_COUNT - 1; i >= 0; i--) begin
      if (slice_map[i] == slice) begin
        led = LED_W'(i);
      end
    end
  end

  assign evt.no_req  = (pending_mask == '0);
  assign evt.iterate = iterate_enable;
  assign evt.slice   = slice;
  assign evt.led     = led;

endmodule

// ===== design/mlbf_queue.sv =====
// Two-entry event queue between the front and the back end.
// Depends on mlbf_pkg.
module mlbf_queue import mlbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output evt_t pop_data
);

  evt_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/mlbf_back.sv =====
// Back end: fade step update, gamma level, round-robin rotation, result register.
// Depends on mlbf_pkg.
module mlbf_back import mlbf_pkg::*; #(
  parameter int LED_COUNT   = 5,
  parameter int LEVEL_STEPS = 257
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  evt_t       q_evt,
  output logic       q_pop,
  input  slice_map_t slice_map,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int STEP_W = $clog2(LEVEL_STEPS);
  localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [STEP_W-1:0] TOP = STEP_W'(LEVEL_STEPS - 1);

  logic [STEP_W-1:0]   fade_r [LED_COUNT];
  logic                rising_r [LED_COUNT];
  logic [LED_W-1:0]    cur_led_r, cur_led_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_r, out_nxt;

  logic [IDX_W-1:0]    idx;
  logic [STEP_W-1:0]   step_cur, step_new;
  logic                ris_cur, ris_new;
  logic [STEP_W:0]     step_inc;
  logic                rot;
  logic [LED_W:0]      led_inc;
  logic [LED_W-1:0]    led_next;
  logic [2*STEP_W-1:0] sq;
  logic [LEVEL_W-1:0]  level;

  // Take an event when the result register is free or being drained
  assign q_pop     = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Step update for the LED of this event
  always_comb begin
    idx      = q_evt.led[IDX_W-1:0];
    step_cur = fade_r[idx];
    ris_cur  = rising_r[idx];
    step_inc = {1'b0, step_cur} + {{STEP_W{1'b0}}, 1'b1};
    rot      = 1'b0;
    if (ris_cur) begin
      if (step_inc >= {1'b0, TOP}) begin
        step_new = TOP;
        ris_new  = 1'b0;
      end else begin
        step_new = step_inc[STEP_W-1:0];
        ris_new  = 1'b1;
      end
    end else begin
      step_new = (step_cur != '0) ? step_cur - {{(STEP_W-1){1'b0}}, 1'b1} : '0;
      ris_new  = (step_new == '0);
      rot      = (step_new == '0) && q_evt.iterate;
    end
  end

  // Round-robin next LED
  always_comb begin
    led_inc  = {1'b0, cur_led_r} + {{LED_W{1'b0}}, 1'b1};
    led_next = (led_inc >= (LED_W+1)'(LED_COUNT)) ? '0 : led_inc[LED_W-1:0];
  end

  // Gamma: square of the step, full scale at the top step
  always_comb begin
    sq    = (2*STEP_W)'(step_new) * (2*STEP_W)'(step_new);
    level = (step_new >= TOP) ? FULL_LEVEL : LEVEL_W'(sq);
  end

  // Next result and active LED
  always_comb begin
    out_nxt     = out_r;
    cur_led_nxt = cur_led_r;
    if (q_pop) begin
      if (q_evt.no_req) begin
        out_nxt            = '0;
        out_nxt.no_request = 1'b1;
        out_nxt.active_led = cur_led_r;
      end else begin
        if (rot) begin
          cur_led_nxt = led_next;
        end
        out_nxt.no_request     = 1'b0;
        out_nxt.serviced_slice = q_evt.slice;
        out_nxt.duty_level     = level;
        out_nxt.rotated        = rot;
        out_nxt.disabled_slice = rot ? slice_map[cur_led_r] : '0;
        out_nxt.enabled_slice  = rot ? slice_map[led_next] : '0;
        out_nxt.active_led     = rot ? led_next : cur_led_r;
      end
    end
    out_valid_nxt = q_pop ? 1'b1 : (res_ready ? 1'b0 : out_valid_r);
  end

  // Control state and per-LED fade state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_led_r   <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        fade_r[i]   <= '0;
        rising_r[i] <= 1'b1;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_led_r   <= cur_led_nxt;
      if (q_pop && !q_evt.no_req) begin
        fade_r[idx]   <= step_new;
        rising_r[idx] <= ris_new;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Active LED stays in range
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_led_r < LED_W'(LED_COUNT)))
    else $error("active LED out of range");

  // Stored step never passes the top
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !q_evt.no_req |-> (step_cur <= TOP))
    else $error("fade step beyond top");

  // Rotation only happens at the fade bottom of a real event
  a_rot_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.rotated |-> (!out_r.no_request && out_r.duty_level == '0))
    else $error("rotation away from fade bottom");

  // An empty mask reports the unchanged active LED
  a_noreq_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.no_request |-> (out_r.active_led == cur_led_r && !out_r.rotated))
    else $error("empty-mask result disagrees with active LED");

endmodule

// ===== design/multi_led_breathing_fader.sv =====
// Top level of the multi-LED breathing fader: stream ports, APB register block,
// front classifier, event queue and back end. Depends on mlbf_pkg and submodules.
//
//   channel | direction | handshake         | content
//   in_     | sink      | tvalid/tready     | wrap event: pending mask, iterate enable
//   out_    | source    | tvalid/tready     | serviced slice, duty level, rotation info
//   cfg_    | APB slave | psel/penable      | led0_slice..led4_slice at 0x00..0x10
//
// One beat per cycle sustained while out_tready stays high; a beat accepted on in_ is
// written to the queue, then moves into the result register and from there onto out_.
// The front end picks the slice and LED combinationally as the beat is queued; the
// back end computes the step update and the square combinationally.
// Synchronous reset (rst_n low) clears fade steps, active LED and queue; all fade up.
// A two-entry queue and the result register let either side stall on its own;
// in_tready drops only while the queue is full.
module multi_led_breathing_fader import mlbf_pkg::*; #(
  parameter int LED_COUNT   = 5,
  parameter int LEVEL_STEPS = 257
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,    // [7:0] pending_mask, [8] iterate_enable
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // [2:0] serviced_slice, [18:3] duty_level,
                                         // [19] rotated, [22:20] disabled_slice,
                                         // [25:23] enabled_slice, [28:26] active_led
  output logic              out_tuser,   // [0] no_request
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  slice_map_t slice_r, slice_nxt;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  evt_t front_evt;
  evt_t q_evt;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;
  res_t res;

  // Register block
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_comb begin
    slice_nxt = slice_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_LED0: slice_nxt[0] = cfg_pwdata[SLICE_W-1:0];
        REG_LED1: slice_nxt[1] = cfg_pwdata[SLICE_W-1:0];
        REG_LED2: slice_nxt[2] = cfg_pwdata[SLICE_W-1:0];
        REG_LED3: slice_nxt[3] = cfg_pwdata[SLICE_W-1:0];
        REG_LED4: slice_nxt[4] = cfg_pwdata[SLICE_W-1:0];
        default:  slice_nxt = slice_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LED0: cfg_prdata = DATA_W'(slice_r[0]);
      REG_LED1: cfg_prdata = DATA_W'(slice_r[1]);
      REG_LED2: cfg_prdata = DATA_W'(slice_r[2]);
      REG_LED3: cfg_prdata = DATA_W'(slice_r[3]);
      REG_LED4: cfg_prdata = DATA_W'(slice_r[4]);
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        slice_r[i] <= SLICE_W'(i);
      end
    end else begin
      slice_r <= slice_nxt;
    end
  end

  // Front end
  mlbf_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .pending_mask   (in_tdata[7:0]),
    .iterate_enable (in_tdata[8]),
    .slice_map      (slice_r),
    .evt            (front_evt)
  );

  // Event queue
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  mlbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_evt),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_evt)
  );

  // Back end
  mlbf_back #(
    .LED_COUNT   (LED_COUNT),
    .LEVEL_STEPS (LEVEL_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_evt     (q_evt),
    .q_pop     (q_pop),
    .slice_map (slice_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Result packing
  assign out_tuser = res.no_request;
  assign out_tdata = {3'b000, res.active_led, res.enabled_slice, res.disabled_slice,
                      res.rotated, res.duty_level, res.serviced_slice};

endmodule

// ===== tb/sv/multi_led_breathing_fader_test.sv =====
// Self-checking testbench for multi_led_breathing_fader: drives wrap events over the
// stream ports and slice mappings over APB, and checks every result against a tracker.
// Depends on mlbf_pkg and the multi_led_breathing_fader RTL.
`timescale 1ns / 100ps

module multi_led_breathing_fader_test;
  import mlbf_pkg::*;

  localparam int LED_COUNT    = 5;
  localparam int LEVEL_STEPS  = 257;
  localparam int TOP_STEP     = LEVEL_STEPS - 1;
  localparam int IDLE_PCT     = 16;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat, config or drain going on

  typedef enum {ITER_OFF, ITER_ON, ITER_RAND} iter_mode_e;

  // Opening events, {iterate_enable, pending_mask}
  localparam logic [8:0] OPENING [18] = '{
    9'h000, 9'h100, 9'h0FF, 9'h101, 9'h002, 9'h104, 9'h008, 9'h110, 9'h020,
    9'h140, 9'h080, 9'h180, 9'h1FE, 9'h0C0, 9'h17F, 9'h0AA, 9'h155, 9'h100
  };

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // [7:0] pending_mask, [8] iterate_enable
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // [2:0] serviced_slice, [18:3] duty_level, [19] rotated,
                                  // [22:20] disabled_slice, [25:23] enabled_slice,
                                  // [28:26] active_led
  logic              out_tuser;   // [0] no_request
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  bit idle_on = 1'b1;
  int beats_sent;

  multi_led_breathing_fader dut (.*);

  // Tracks the fade state of every LED and queues the result each event should give
  class fade_tracker;
    logic [SLICE_W-1:0] slice_map [REG_COUNT];
    int                 fade_step [LED_COUNT];
    bit                 heading_up [LED_COUNT];
    int                 cur_led;
    res_t               expected_fades [$];
    int mismatches, checked;
    int n_empty, n_unmatched, n_top, n_rotations, n_bottom_held;

    function new();
      for (int i = 0; i < REG_COUNT; i++) slice_map[i] = SLICE_W'(i);
      for (int i = 0; i < LED_COUNT; i++) begin
        fade_step[i] = 0;
        heading_up[i] = 1'b1;
      end
      cur_led = 0;
    endfunction

    function void set_slice(int idx, logic [SLICE_W-1:0] val);
      slice_map[idx] = val;
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function logic [SLICE_W-1:0] slice_of_led(int led);
      if (led >= REG_COUNT) led = 0;
      return slice_map[led];
    endfunction

    // One wrap event: step the picked LED and queue the resulting beat
    function void apply_wrap_event(logic [MASK_W-1:0] mask, logic iter);
      res_t r;
      int   sl, led, step, nxt;
      bit   found;
      r = '0;
      if (mask == '0) begin
        n_empty++;
        r.no_request = 1'b1;
        r.active_led = LED_W'(cur_led);
        expected_fades.push_back(r);
        return;
      end
      sl = 0;
      for (int k = MASK_W - 1; k >= 0; k--) if (mask[k]) sl = k;
      led = 0;
      found = 1'b0;
      for (int i = 0; i < LED_COUNT && i < REG_COUNT; i++)
        if (!found && slice_map[i] == SLICE_W'(sl)) begin
          led = i;
          found = 1'b1;
        end
      if (!found) n_unmatched++;

      step = fade_step[led];
      if (heading_up[led]) begin
        step++;
        if (step >= TOP_STEP) begin
          step = TOP_STEP;
          heading_up[led] = 1'b0;
        end
      end else begin
        if (step > 0) step--;
        if (step == 0) begin
          heading_up[led] = 1'b1;
          if (iter) begin
            nxt = cur_led + 1;
            if (nxt >= LED_COUNT) nxt = 0;
            r.rotated = 1'b1;
            r.disabled_slice = slice_of_led(cur_led);
            r.enabled_slice = slice_of_led(nxt);
            cur_led = nxt;
            n_rotations++;
          end else begin
            n_bottom_held++;
          end
        end
      end
      fade_step[led] = step;

      r.serviced_slice = SLICE_W'(sl);
      if (step >= TOP_STEP) begin
        r.duty_level = FULL_LEVEL;
        n_top++;
      end else begin
        r.duty_level = LEVEL_W'(step * step);
      end
      r.active_led = LED_W'(cur_led);
      expected_fades.push_back(r);
    endfunction

    // Compare one result beat with the oldest queued expectation
    function void check_fader_result(logic [31:0] data, logic user);
      res_t got, exp;
      got.no_request     = user;
      got.serviced_slice = data[2:0];
      got.duty_level     = data[18:3];
      got.rotated        = data[19];
      got.disabled_slice = data[22:20];
      got.enabled_slice  = data[25:23];
      got.active_led     = data[28:26];
      if (expected_fades.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected, tdata=%h", data));
        return;
      end
      exp = expected_fades.pop_front();
      checked++;
      if (got.no_request !== exp.no_request)
        flag_mismatch($sformatf("no_request %b, want %b", got.no_request, exp.no_request));
      if (got.serviced_slice !== exp.serviced_slice)
        flag_mismatch($sformatf("serviced_slice %0d, want %0d",
                                got.serviced_slice, exp.serviced_slice));
      if (got.duty_level !== exp.duty_level)
        flag_mismatch($sformatf("duty_level %h, want %h", got.duty_level, exp.duty_level));
      if (got.rotated !== exp.rotated)
        flag_mismatch($sformatf("rotated %b, want %b", got.rotated, exp.rotated));
      if (got.disabled_slice !== exp.disabled_slice)
        flag_mismatch($sformatf("disabled_slice %0d, want %0d",
                                got.disabled_slice, exp.disabled_slice));
      if (got.enabled_slice !== exp.enabled_slice)
        flag_mismatch($sformatf("enabled_slice %0d, want %0d",
                                got.enabled_slice, exp.enabled_slice));
      if (got.active_led !== exp.active_led)
        flag_mismatch($sformatf("active_led %0d, want %0d", got.active_led, exp.active_led));
    endfunction
  endclass

  fade_tracker fades = new();

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: ready drops at random while idling is on
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end
  end

  // Result checking
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) fades.check_fader_result(out_tdata, out_tuser);

  // Watchdog: ends the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("multi_led_breathing_fader regression: fail");
        $finish;
      end
    end
  end

  // One wrap event beat, with random idle cycles ahead of it
  task automatic send_wrap(logic [MASK_W-1:0] mask, logic iter);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, iter, mask};
    do @(posedge clk); while (!in_tready);
    fades.apply_wrap_event(mask, iter);
    beats_sent++;
  endtask

  task automatic send_noise(int n);
    logic [MASK_W-1:0] mask;
    for (int i = 0; i < n; i++) begin
      mask = ($urandom_range(0, 7) == 0) ? '0 : MASK_W'($urandom);
      send_wrap(mask, 1'($urandom));
    end
  endtask

  // Hammer the LEDs behind the allowed slices so fades reach both ends;
  // the lowest pending bit is a target, higher bits are random
  task automatic sweep(logic [MASK_W-1:0] allowed, int hits, iter_mode_e mode);
    logic [2:0]        tgt;
    logic [MASK_W-1:0] mask;
    logic              iter;
    int                done;
    done = 0;
    while (done < hits) begin
      if ($urandom_range(0, 15) == 0) begin
        send_noise(1);
      end else begin
        do tgt = 3'($urandom_range(0, 7)); while (!allowed[tgt]);
        mask = (MASK_W'($urandom) & (8'hFF << tgt)) | (8'h01 << tgt);
        case (mode)
          ITER_OFF: iter = 1'b0;
          ITER_ON:  iter = 1'b1;
          default:  iter = 1'($urandom);
        endcase
        send_wrap(mask, iter);
        done++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (fades.expected_fades.size() != 0) @(posedge clk);
  endtask

  // APB write, then read back and compare
  task automatic reg_write(logic [2:0] idx, logic [SLICE_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= DATA_W'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fades.set_slice(idx, val);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== DATA_W'(val))
      fades.flag_mismatch($sformatf("register %0d reads %h, want %0d", idx, cfg_prdata, val));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write all slice registers; only called with the fader drained
  task automatic program_map(slice_map_t m);
    reg_write(REG_LED0, m[REG_LED0]);
    reg_write(REG_LED1, m[REG_LED1]);
    reg_write(REG_LED2, m[REG_LED2]);
    reg_write(REG_LED3, m[REG_LED3]);
    reg_write(REG_LED4, m[REG_LED4]);
  endtask

  // Stimulus
  initial begin
    slice_map_t rnd_map;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    beats_sent  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty masks, single bits, unmatched slices, wide masks
    foreach (OPENING[i]) send_wrap(OPENING[i][7:0], OPENING[i][8]);
    wait_drained();

    // Identity map; drive LED 0 (slice 0 plus unmatched 5..7) through a full
    // breath so it tops out and rotates at the bottom
    program_map({3'd4, 3'd3, 3'd2, 3'd1, 3'd0});
    sweep(8'hE1, 150, ITER_ON);
    idle_on = 1'b0;
    sweep(8'hE1, 200, ITER_ON);
    idle_on = 1'b1;
    wait_drained();
    sweep(8'hE1, 170, ITER_ON);
    wait_drained();

    // Every LED on the top slice, then on slice 0
    program_map({3'd7, 3'd7, 3'd7, 3'd7, 3'd7});
    send_noise(40);
    wait_drained();
    program_map({3'd0, 3'd0, 3'd0, 3'd0, 3'd0});
    send_noise(40);
    wait_drained();

    // LED 2 on slice 0: full breath with iterate off, so it bottoms without rotating
    program_map({3'd1, 3'd5, 3'd0, 3'd6, 3'd3});
    sweep(8'h01, 520, ITER_OFF);
    wait_drained();

    // Random mapping, random events
    for (int i = 0; i < REG_COUNT; i++) rnd_map[i] = 3'($urandom_range(0, 7));
    program_map(rnd_map);
    send_noise(80);

    // Wrap up
    wait_drained();
    repeat (4) @(posedge clk);
    foreach (fades.expected_fades[i])
      fades.flag_mismatch($sformatf("expected result %0d never arrived", i));
    $display("sent %0d wrap events, checked %0d results: %0d empty, %0d unmatched slices",
             beats_sent, fades.checked, fades.n_empty, fades.n_unmatched);
    $display("fade tops %0d, rotations %0d, bottoms without rotation %0d, mismatches %0d",
             fades.n_top, fades.n_rotations, fades.n_bottom_held, fades.mismatches);
    if (fades.mismatches == 0)
      $display("multi_led_breathing_fader regression: pass");
    else
      $display("multi_led_breathing_fader regression: fail");
    $finish;
  end

endmodule
